>>> sv/sbss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbss_pkg
// Types, codes and defaults shared by the sorted byte set store.
// ----------------------------------------------------------------------------
package sbss_pkg;

  localparam int SBSS_DEPTH = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [7:0] element;
  } sbss_in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] set_size;
    logic [1:0] status;
  } sbss_out_t;

endpackage

>>> sv/sorted_byte_set_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_byte_set_store_top
// Ordered set of distinct signed bytes held in one entry RAM.
// Each operation scans for the lower bound; a stored insert then shifts the
// entries above it up, and a delete shifts them down, before the strobe;
// busy drops with the strobe, so the next beat may start that cycle.
// The entry RAM has a single read port, so scan and shifts read one entry at a time.
// Reset empties the set at once, RAM contents are kept; the receiver never stalls.
// ----------------------------------------------------------------------------
module sorted_byte_set_store_top #(
  parameter int DEPTH = sbss_pkg::SBSS_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sbss_pkg::sbss_in_t  in_data,
  output logic                out_valid,
  output sbss_pkg::sbss_out_t out_data
);
  import sbss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  sbss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  sbss_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

>>> sv/sbss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/sbss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbss_ctrl
// Sequencer: scans the entry RAM for the lower bound, then shifts entries
// up or down one at a time, each read then written, and reports one result beat.
// ----------------------------------------------------------------------------
module sbss_ctrl #(
  parameter int DEPTH = sbss_pkg::SBSS_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sbss_pkg::sbss_in_t  in_data,
  output logic                out_valid,
  output sbss_pkg::sbss_out_t out_data,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output logic [7:0]          mem_wr_data,
  output logic [AW-1:0]       mem_rd_addr,
  input  logic [7:0]          mem_rd_data
);
  import sbss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_UP_RD    = 4'd4;
  localparam logic [3:0] S_UP_WR    = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_DN_RD    = 4'd7;
  localparam logic [3:0] S_DN_WR    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              present_r, present_nxt;
  logic [1:0]        op_r, op_nxt;
  logic signed [7:0] elem_r, elem_nxt;
  logic              out_valid_r, out_valid_nxt;
  sbss_out_t         out_data_r, out_data_nxt;
  logic [CW-1:0]     k_dec, k_inc;

  assign k_dec = k_r - CNT_ONE;
  assign k_inc = k_r + CNT_ONE;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    present_nxt   = present_r;
    op_nxt        = op_r;
    elem_nxt      = elem_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = k_r[AW-1:0];
    mem_wr_data   = mem_rd_data;
    mem_rd_addr   = pos_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.operation;
          elem_nxt  = in_data.element;
          pos_nxt   = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (pos_r == cnt_r) begin
          present_nxt = 1'b0;
          state_nxt   = S_DECIDE;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if ($signed(mem_rd_data) < elem_r) begin
          pos_nxt   = pos_r + CNT_ONE;
          state_nxt = S_SCAN_RD;
        end else begin
          present_nxt = ($signed(mem_rd_data) == elem_r);
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        out_data_nxt.found    = present_r;
        out_data_nxt.set_size = 4'(cnt_r);
        out_data_nxt.status   = ST_DONE;
        if (op_r == OP_INSERT) begin
          if (present_r) begin
            out_data_nxt.status = ST_DUP;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end else if (cnt_r == CNT_FULL) begin
            out_data_nxt.status = ST_FULL;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            k_nxt     = cnt_r;
            state_nxt = S_UP_RD;
          end
        end else if (op_r == OP_DELETE) begin
          if (present_r) begin
            k_nxt     = pos_r;
            state_nxt = S_DN_RD;
          end else begin
            out_data_nxt.status = ST_ABSENT;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_UP_RD: begin
        mem_rd_addr = k_dec[AW-1:0];
        if (k_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = k_r[AW-1:0];
        k_nxt       = k_dec;
        state_nxt   = S_UP_RD;
      end
      S_INS_WR: begin
        mem_wr_en             = 1'b1;
        mem_wr_addr           = pos_r[AW-1:0];
        mem_wr_data           = elem_r;
        cnt_nxt               = cnt_r + CNT_ONE;
        out_data_nxt.set_size = 4'(cnt_nxt);
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      S_DN_RD: begin
        mem_rd_addr = k_inc[AW-1:0];
        if (k_inc >= cnt_r) begin
          cnt_nxt               = cnt_r - CNT_ONE;
          out_data_nxt.set_size = 4'(cnt_nxt);
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = k_r[AW-1:0];
        k_nxt       = k_inc;
        state_nxt   = S_DN_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    present_r  <= present_nxt;
    op_r       <= op_nxt;
    elem_r     <= elem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
